// ----- design/cmapf4_pkg.sv -----
// ----------------------------------------------------------------------------
// cmapf4_pkg
// shared widths, codes and channel structs of the cmap format 4 lookup block
// ----------------------------------------------------------------------------
package cmapf4_pkg;

  localparam int TABLE_BYTES_DEF = 8192;

  localparam int SEG_W   = 10;
  localparam int LEN_W   = 14;
  localparam int GLYPH_W = 16;
  localparam int CP_W    = 16;
  localparam int LADDR_W = 13;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 14;
  localparam int CFG_IDX_W = 1;

  // byte address arithmetic, wide enough for range offset plus code point span
  localparam int POS_W = 20;

  // subtable layout
  localparam int END_CODES_OFS = 14;
  localparam int HEADER_BYTES  = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBTABLE_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_GLYPH  = 2'd1,
    STATUS_BAD_LAYOUT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_END,
    S_RD_START,
    S_RD_DELTA,
    S_RD_RANGE,
    S_CHK_POS,
    S_RD_GLYPH
  } scan_state_e;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
  } word_rd_t;

  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } byte_wr_t;

  typedef struct packed {
    logic               valid;
    logic [GLYPH_W-1:0] glyph;
    status_e            status;
  } result_t;

endpackage

// ----- design/cmapf4_word_store.sv -----
// ----------------------------------------------------------------------------
// cmapf4_word_store
// subtable byte store split into even and odd banks, one big-endian word
// read per cycle at any byte address, one byte write per cycle
// ----------------------------------------------------------------------------
module cmapf4_word_store #(
  parameter int TABLE_BYTES = cmapf4_pkg::TABLE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  cmapf4_pkg::byte_wr_t          wr_i,
  input  cmapf4_pkg::word_rd_t          rd_i,
  output logic [2*cmapf4_pkg::BYTE_W-1:0] rd_data_o
);

  localparam int ADDR_W     = $clog2(TABLE_BYTES);
  localparam int BANK_W     = ADDR_W - 1;
  localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;

  logic [cmapf4_pkg::BYTE_W-1:0] even_mem [BANK_DEPTH];
  logic [cmapf4_pkg::BYTE_W-1:0] odd_mem  [BANK_DEPTH];

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [BANK_W-1:0] even_idx;
  logic [BANK_W-1:0] odd_idx;

  logic [cmapf4_pkg::BYTE_W-1:0] even_q;
  logic [cmapf4_pkg::BYTE_W-1:0] odd_q;
  logic                          odd_sel_q;

  assign wr_addr = wr_i.addr[ADDR_W-1:0];
  assign rd_addr = rd_i.addr[ADDR_W-1:0];

  // odd start: high byte from odd bank, low byte from next even entry
  assign odd_idx  = rd_addr[ADDR_W-1:1];
  assign even_idx = rd_addr[0] ? BANK_W'(rd_addr[ADDR_W-1:1] + 1'b1) : rd_addr[ADDR_W-1:1];

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_addr[0]) begin
      even_mem[wr_addr[ADDR_W-1:1]] <= wr_i.data;
    end
    if (wr_i.en && wr_addr[0]) begin
      odd_mem[wr_addr[ADDR_W-1:1]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      even_q    <= even_mem[even_idx];
      odd_q     <= odd_mem[odd_idx];
      odd_sel_q <= rd_addr[0];
    end
  end

  assign rd_data_o = odd_sel_q ? {odd_q, even_q} : {even_q, odd_q};

endmodule

// ----- design/cmapf4_scan.sv -----
// ----------------------------------------------------------------------------
// cmapf4_scan
// lookup sequencer: layout check, linear segment scan, glyph word fetch
// ----------------------------------------------------------------------------
module cmapf4_scan #(
  parameter int TABLE_BYTES = cmapf4_pkg::TABLE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             go_i,
  input  logic [cmapf4_pkg::CP_W-1:0]      code_point_i,
  input  logic [cmapf4_pkg::SEG_W-1:0]     seg_count_i,
  input  logic [cmapf4_pkg::LEN_W-1:0]     sub_len_i,
  input  logic [cmapf4_pkg::GLYPH_W-1:0]   rd_data_i,
  output logic                             busy_o,
  output cmapf4_pkg::word_rd_t             rd_o,
  output cmapf4_pkg::result_t              res_o
);

  localparam int POS_W = cmapf4_pkg::POS_W;
  localparam int CP_W  = cmapf4_pkg::CP_W;
  localparam int SEG_W = cmapf4_pkg::SEG_W;

  cmapf4_pkg::scan_state_e state_q, state_d;
  logic [SEG_W-1:0]   seg_q, seg_d;
  logic [POS_W-1:0]   addr_q, addr_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [CP_W-1:0]    cp_q, cp_d;
  logic [CP_W-1:0]    delta_q, delta_d;
  logic [CP_W:0]      diff2_q, diff2_d;
  cmapf4_pkg::result_t res_q, res_d;

  logic [POS_W-1:0] n2;
  logic [POS_W-1:0] len_w;
  logic [POS_W-1:0] arrays_end;
  logic             layout_bad;
  logic             last_seg;

  assign n2         = POS_W'({seg_count_i, 1'b0});
  assign len_w      = POS_W'(sub_len_i);
  assign arrays_end = POS_W'(cmapf4_pkg::HEADER_BYTES) + POS_W'({seg_count_i, 3'b000});
  assign layout_bad = (len_w > POS_W'(TABLE_BYTES)) || (arrays_end > len_w);
  assign last_seg   = ({1'b0, seg_q} + 1'b1) == {1'b0, seg_count_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmapf4_pkg::S_IDLE;
      seg_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    pos_q   <= pos_d;
    cp_q    <= cp_d;
    delta_q <= delta_d;
    diff2_q <= diff2_d;
  end

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    addr_d      = addr_q;
    pos_d       = pos_q;
    cp_d        = cp_q;
    delta_d     = delta_q;
    diff2_d     = diff2_q;
    res_d       = '0;
    res_d.status = cmapf4_pkg::STATUS_OK;
    rd_o.en     = 1'b0;

    unique case (state_q)
      cmapf4_pkg::S_IDLE: begin
        if (go_i) begin
          cp_d = code_point_i;
          if (layout_bad) begin
            res_d.valid  = 1'b1;
            res_d.status = cmapf4_pkg::STATUS_BAD_LAYOUT;
          end else if (seg_count_i == '0) begin
            res_d.valid = 1'b1;
          end else begin
            addr_d  = POS_W'(cmapf4_pkg::END_CODES_OFS);
            rd_o.en = 1'b1;
            state_d = cmapf4_pkg::S_RD_END;
          end
        end
      end
      cmapf4_pkg::S_RD_END: begin
        if (cp_q > rd_data_i) begin
          if (last_seg) begin
            res_d.valid = 1'b1;
            seg_d       = '0;
            state_d     = cmapf4_pkg::S_IDLE;
          end else begin
            seg_d   = SEG_W'(seg_q + 1'b1);
            addr_d  = POS_W'(addr_q + 2'd2);
            rd_o.en = 1'b1;
          end
        end else begin
          // start code sits one pad word plus one array further on
          addr_d  = POS_W'(addr_q + n2 + 2'd2);
          rd_o.en = 1'b1;
          state_d = cmapf4_pkg::S_RD_START;
        end
      end
      cmapf4_pkg::S_RD_START: begin
        if (cp_q < rd_data_i) begin
          res_d.valid = 1'b1;
          seg_d       = '0;
          state_d     = cmapf4_pkg::S_IDLE;
        end else begin
          diff2_d = {CP_W'(cp_q - rd_data_i), 1'b0};
          addr_d  = POS_W'(addr_q + n2);
          rd_o.en = 1'b1;
          state_d = cmapf4_pkg::S_RD_DELTA;
        end
      end
      cmapf4_pkg::S_RD_DELTA: begin
        delta_d = rd_data_i;
        addr_d  = POS_W'(addr_q + n2);
        rd_o.en = 1'b1;
        state_d = cmapf4_pkg::S_RD_RANGE;
      end
      cmapf4_pkg::S_RD_RANGE: begin
        if (rd_data_i == '0) begin
          res_d.valid = 1'b1;
          res_d.glyph = CP_W'(cp_q + delta_q);
          seg_d       = '0;
          state_d     = cmapf4_pkg::S_IDLE;
        end else begin
          // offset is relative to this segment's range offset word
          pos_d   = POS_W'(addr_q + POS_W'(rd_data_i) + POS_W'(diff2_q));
          state_d = cmapf4_pkg::S_CHK_POS;
        end
      end
      cmapf4_pkg::S_CHK_POS: begin
        if (POS_W'(pos_q + 2'd2) > len_w || pos_q > len_w) begin
          res_d.valid  = 1'b1;
          res_d.status = cmapf4_pkg::STATUS_BAD_GLYPH;
          seg_d        = '0;
          state_d      = cmapf4_pkg::S_IDLE;
        end else begin
          addr_d  = pos_q;
          rd_o.en = 1'b1;
          state_d = cmapf4_pkg::S_RD_GLYPH;
        end
      end
      cmapf4_pkg::S_RD_GLYPH: begin
        res_d.valid = 1'b1;
        res_d.glyph = (rd_data_i == '0) ? '0 : CP_W'(rd_data_i + delta_q);
        seg_d       = '0;
        state_d     = cmapf4_pkg::S_IDLE;
      end
      default: begin
        state_d = cmapf4_pkg::S_IDLE;
      end
    endcase

    rd_o.addr = addr_d;
  end

  assign busy_o    = state_q != cmapf4_pkg::S_IDLE;
  assign res_o     = res_q;

  // a result follows either a scan step or a lookup taken while idle
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid |-> ($past(state_q) != cmapf4_pkg::S_IDLE) || $past(go_i))
    else $error("result without a lookup");

  a_err_zero_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid && res_q.status != cmapf4_pkg::STATUS_OK |-> res_q.glyph == '0)
    else $error("error result with nonzero glyph");

  a_cursor_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cmapf4_pkg::S_IDLE |-> seg_q == '0)
    else $error("segment cursor not cleared after lookup");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cmapf4_pkg::S_RD_END |-> {1'b0, seg_q} < {1'b0, seg_count_i})
    else $error("segment cursor past segment count");

endmodule

// ----- design/cmap_format4_glyph_lookup_top.sv -----
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup_top
// truetype cmap format 4 subtable store and code point to glyph lookup
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low. A load word writes
// one subtable byte in that cycle and gives no result; loads can follow each
// other every cycle. A lookup word gives exactly one result on
// result_valid_o for one cycle; the receiver cannot stall it. A layout error
// or a zero segment count answers in the cycle after the word is taken. A
// scan that stops at segment j keeps busy_o high while it walks end codes
// 0 to j, then as needed start code, delta, range offset, bounds check and
// glyph word; the result shows in the cycle busy_o falls. The pace is set
// by the store's single word read port: one 16-bit field per cycle, read
// through a register. Configuration must be written only while no lookup
// is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cmap_format4_glyph_lookup_top #(
  parameter int TABLE_BYTES = cmapf4_pkg::TABLE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command side
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               operation_i,
  input  logic [cmapf4_pkg::LADDR_W-1:0]     load_address_i,
  input  logic [cmapf4_pkg::BYTE_W-1:0]      load_value_i,
  input  logic [cmapf4_pkg::CP_W-1:0]        code_point_i,
  // result side
  output logic                               result_valid_o,
  output logic [cmapf4_pkg::GLYPH_W-1:0]     glyph_index_o,
  output logic [1:0]                         status_o,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [cmapf4_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cmapf4_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int POS_W = cmapf4_pkg::POS_W;

  logic [cmapf4_pkg::SEG_W-1:0] seg_count_q;
  logic [cmapf4_pkg::LEN_W-1:0] sub_len_q;

  logic                           accept;
  logic                           scan_busy;
  cmapf4_pkg::byte_wr_t           wr;
  cmapf4_pkg::word_rd_t           rd;
  logic [cmapf4_pkg::GLYPH_W-1:0] rd_data;
  cmapf4_pkg::result_t            res;

  // configuration registers, plain write with no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= cmapf4_pkg::SEG_W'(1);
      sub_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cmapf4_pkg::REG_SEGMENT_COUNT:   seg_count_q <= cfg_data_i[cmapf4_pkg::SEG_W-1:0];
        cmapf4_pkg::REG_SUBTABLE_LENGTH: sub_len_q   <= cfg_data_i[cmapf4_pkg::LEN_W-1:0];
      endcase
    end
  end

  assign accept = start_i && !scan_busy;

  // loads beyond the store are dropped; the scan is idle whenever a load lands,
  // so a write never meets a lookup read
  assign wr.en   = accept && (operation_i == cmapf4_pkg::OP_LOAD) &&
                   (POS_W'(load_address_i) < POS_W'(TABLE_BYTES));
  assign wr.addr = POS_W'(load_address_i);
  assign wr.data = load_value_i;

  cmapf4_word_store #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  cmapf4_scan #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (accept && (operation_i == cmapf4_pkg::OP_LOOKUP)),
    .code_point_i (code_point_i),
    .seg_count_i  (seg_count_q),
    .sub_len_i    (sub_len_q),
    .rd_data_i    (rd_data),
    .busy_o       (scan_busy),
    .rd_o         (rd),
    .res_o        (res)
  );

  assign busy_o         = scan_busy;
  assign result_valid_o = res.valid;
  assign glyph_index_o  = res.glyph;
  assign status_o       = res.status;

endmodule

// ----- dv/tb_cmap_format4_glyph_lookup_top.sv -----
// ----------------------------------------------------------------------------
// tb_cmap_format4_glyph_lookup_top
// self-checking bench for the cmap format 4 subtable store and glyph lookup
// ----------------------------------------------------------------------------
// Directed words cover the register extremes first: zero length, a length
// past the store, zero segments, and 1022 segments, the most that fit, with
// the arrays just fitting or just overflowing. These words also hit the
// glyph word at the end of the store and glyph offsets past the length.
// Random phases then build well-formed subtables with random segments,
// deltas and glyph arrays. Each phase sometimes gets a cut or stretched
// length, and runs lookups near segment edges, mixed with stray byte loads.
// A shadow of the store predicts every lookup. The scoreboard compares each
// result strobe against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        op;
  logic [12:0] load_addr;
  logic [7:0]  load_val;
  logic [15:0] cp;
} cmap_word_t;

typedef struct packed {
  logic [15:0]         glyph;
  cmapf4_pkg::status_e status;
} glyph_result_t;

class glyph_scoreboard;
  logic [7:0]    store [cmapf4_pkg::TABLE_BYTES_DEF];
  bit            written [cmapf4_pkg::TABLE_BYTES_DEF];
  int unsigned   seg_count;
  int unsigned   table_len;
  glyph_result_t mapped_q [$];
  bit            undefined_read;
  int            errors;
  int            loads;
  int            lookups;
  int            outcome_cnt [3];

  function new();
    seg_count = 1;
    table_len = 0;
  endfunction

  function void set_reg(input logic [cmapf4_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    if (idx == cmapf4_pkg::REG_SEGMENT_COUNT) begin
      seg_count = value & 'h3FF;
    end else begin
      table_len = value & 'h3FFF;
    end
  endfunction

  function int unsigned byte_at(input int unsigned a);
    if (a >= cmapf4_pkg::TABLE_BYTES_DEF) begin
      return 0;
    end
    if (!written[a]) begin
      undefined_read = 1'b1;
    end
    return store[a];
  endfunction

  // big-endian field
  function int unsigned word_at(input int unsigned a);
    return (byte_at(a) << 8) | byte_at(a + 1);
  endfunction

  function glyph_result_t map_code(input logic [15:0] cp);
    glyph_result_t r;
    int unsigned   n, starts, deltas, ranges, last, first, delta, roff, pos, g;
    n      = seg_count;
    starts = cmapf4_pkg::HEADER_BYTES + 2 * n;
    deltas = starts + 2 * n;
    ranges = deltas + 2 * n;
    r.glyph  = '0;
    r.status = cmapf4_pkg::STATUS_OK;
    undefined_read = 1'b0;
    if (table_len > cmapf4_pkg::TABLE_BYTES_DEF || ranges + 2 * n > table_len) begin
      r.status = cmapf4_pkg::STATUS_BAD_LAYOUT;
    end else begin
      for (int i = 0; i < n; i++) begin
        last  = word_at(cmapf4_pkg::END_CODES_OFS + 2 * i);
        first = word_at(starts + 2 * i);
        if (cp > last) continue;
        if (cp < first) break;
        delta = word_at(deltas + 2 * i);
        roff  = word_at(ranges + 2 * i);
        if (roff == 0) begin
          r.glyph = 16'(cp + delta);
          break;
        end
        pos = ranges + 2 * i + roff + 2 * (cp - first);
        if (pos + 2 > table_len) begin
          r.status = cmapf4_pkg::STATUS_BAD_GLYPH;
          break;
        end
        g = word_at(pos);
        r.glyph = (g == 0) ? 16'h0000 : 16'(g + delta);
        break;
      end
    end
    return r;
  endfunction

  function bit reads_undefined(input logic [15:0] cp);
    void'(map_code(cp));
    return undefined_read;
  endfunction

  function void note_word(input cmap_word_t w);
    glyph_result_t r;
    if (w.op == cmapf4_pkg::OP_LOAD) begin
      store[w.load_addr]   = w.load_val;
      written[w.load_addr] = 1'b1;
      loads++;
    end else begin
      r = map_code(w.cp);
      mapped_q.push_back(r);
      lookups++;
      outcome_cnt[r.status]++;
    end
  endfunction

  function void check_result(input logic [15:0] glyph, input logic [1:0] status);
    glyph_result_t exp;
    if (mapped_q.size() == 0) begin
      $error("result with no lookup waiting: glyph_index %h status %0d", glyph, status);
      errors++;
      return;
    end
    exp = mapped_q.pop_front();
    if (glyph !== exp.glyph) begin
      $error("glyph_index: expected %h, got %h", exp.glyph, glyph);
      errors++;
    end
    if (status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, status);
      errors++;
    end
  endfunction

  function int pending();
    return mapped_q.size();
  endfunction
endclass

module tb_cmap_format4_glyph_lookup_top;
  import cmapf4_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int ITEMS_TARGET = 650;
  localparam int CALM_ITEMS   = 80;   // no idling over the last stretch

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 op;
  logic [LADDR_W-1:0]   load_addr;
  logic [BYTE_W-1:0]    load_val;
  logic [CP_W-1:0]      cp;
  logic                 res_valid;
  logic [GLYPH_W-1:0]   glyph;
  logic [1:0]           status;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  glyph_scoreboard sb;
  int              items;
  int              settings;
  bit              idling_on;
  int unsigned     seg_lo [$];
  int unsigned     seg_hi [$];

  cmap_format4_glyph_lookup_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .operation_i    (op),
    .load_address_i (load_addr),
    .load_value_i   (load_val),
    .code_point_i   (cp),
    .result_valid_o (res_valid),
    .glyph_index_o  (glyph),
    .status_o       (status),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    if (rst_n && res_valid) begin
      sb.check_result(glyph, status);
    end
  end

  // one word: optional idle burst, then hold start until the block takes it
  task automatic send(input cmap_word_t w);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk) start = 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    start     = 1'b1;
    op        = w.op;
    load_addr = w.load_addr;
    load_val  = w.load_val;
    cp        = w.cp;
    do @(posedge clk); while (busy);
    sb.note_word(w);
    items++;
  endtask

  task automatic load_byte(input int unsigned a, input int unsigned v);
    cmap_word_t w;
    w = '{op: OP_LOAD, load_addr: LADDR_W'(a), load_val: BYTE_W'(v), cp: CP_W'($urandom)};
    send(w);
  endtask

  task automatic look_up(input int unsigned c);
    cmap_word_t w;
    w = '{op: OP_LOOKUP, load_addr: LADDR_W'($urandom), load_val: BYTE_W'($urandom),
          cp: CP_W'(c)};
    send(w);
  endtask

  // drop start, wait for every lookup to answer and for the block to go quiet
  task automatic settle();
    @(negedge clk) start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_W'(value);
    sb.set_reg(idx, value);
    @(negedge clk) cfg_we = 1'b0;
    settings++;
  endtask

  function automatic void put_word(ref logic [7:0] img [], input int unsigned a,
                                   input int unsigned v);
    img[a]     = v[15:8];
    img[a + 1] = v[7:0];
  endfunction

  // lookup near segment edges, anywhere, or at the code point extremes;
  // a pick that would touch a never-loaded byte is redrawn
  task automatic random_lookup();
    int unsigned c, j, lo, hi;
    int          tries;
    for (tries = 0; tries < 16; tries++) begin
      case ($urandom_range(0, 9))
        7, 8:    c = $urandom_range(0, 65535);
        9:       c = $urandom_range(0, 1) ? 65535 : 0;
        default: begin
          if (seg_lo.size() == 0) begin
            c = $urandom_range(0, 65535);
          end else begin
            j  = $urandom_range(0, seg_lo.size() - 1);
            lo = (seg_lo[j] == 0) ? 0 : seg_lo[j] - 1;
            hi = (seg_hi[j] == 65535) ? 65535 : seg_hi[j] + 1;
            c  = $urandom_range(lo, hi);
          end
        end
      endcase
      if (!sb.reads_undefined(CP_W'(c))) break;
    end
    if (tries < 16) begin
      look_up(c);
    end else begin
      load_byte($urandom_range(0, TABLE_BYTES_DEF - 1), $urandom_range(0, 255));
    end
  endtask

  // lay out a well-formed format 4 subtable, program the registers, load it
  task automatic build_table(input int unsigned n);
    logic [7:0]  image [];
    int unsigned glyph_words [$];
    int unsigned seg_delta [];
    int unsigned seg_roff [];
    int unsigned c, lo, hi, gap, span, total, len;
    bit          with_array;
    seg_delta = new[n];
    seg_roff  = new[n];
    seg_lo.delete();
    seg_hi.delete();
    c = $urandom_range(0, 1500);
    for (int i = 0; i < n; i++) begin
      with_array = ($urandom_range(0, 1) == 1) && (glyph_words.size() < 24);
      gap  = $urandom_range(0, 50000 / n);
      span = with_array ? $urandom_range(0, 5) : $urandom_range(0, 2500);
      lo   = (c + gap > 65535) ? 65535 : c + gap;
      hi   = (lo + span > 65535) ? 65535 : lo + span;
      seg_delta[i] = $urandom_range(0, 65535);
      // closing sentinel segment as real fonts carry it
      if (i == n - 1 && $urandom_range(0, 1) == 1) begin
        lo = 65535;
        hi = 65535;
        with_array   = 1'b0;
        seg_delta[i] = 1;
      end
      if (with_array) begin
        // points at the next free glyph array slot
        seg_roff[i] = 2 * n + 2 * (glyph_words.size() - i);
        repeat (hi - lo + 1) begin
          glyph_words.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535));
        end
      end else begin
        seg_roff[i] = 0;
      end
      seg_lo.push_back(lo);
      seg_hi.push_back(hi);
      c = hi + 1;
    end
    total = HEADER_BYTES + 8 * n + 2 * glyph_words.size();
    image = new[total];
    foreach (image[k]) image[k] = 8'h00;
    put_word(image, 0, 4);
    put_word(image, 2, total);
    put_word(image, 6, 2 * n);
    for (int k = 8; k < END_CODES_OFS; k++) image[k] = BYTE_W'($urandom);
    for (int i = 0; i < n; i++) begin
      put_word(image, END_CODES_OFS + 2 * i, seg_hi[i]);
      put_word(image, HEADER_BYTES + 2 * n + 2 * i, seg_lo[i]);
      put_word(image, HEADER_BYTES + 4 * n + 2 * i, seg_delta[i]);
      put_word(image, HEADER_BYTES + 6 * n + 2 * i, seg_roff[i]);
    end
    foreach (glyph_words[w]) put_word(image, HEADER_BYTES + 8 * n + 2 * w, glyph_words[w]);

    // mostly the true length; sometimes cut, stretched or past the store
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(TABLE_BYTES_DEF + 1, 16383);
      1:       len = total - $urandom_range(1, 16);
      2:       len = total + 2 * $urandom_range(1, 8);
      default: len = total;
    endcase

    settle();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_SEGMENT_COUNT, n);
      write_reg(REG_SUBTABLE_LENGTH, len);
    end else begin
      write_reg(REG_SUBTABLE_LENGTH, len);
      write_reg(REG_SEGMENT_COUNT, n);
    end
    foreach (image[k]) load_byte(k, image[k]);
  endtask

  initial begin
    int unsigned n;
    int          lookups_at_random;
    start     = 1'b0;
    op        = OP_LOAD;
    load_addr = '0;
    load_val  = '0;
    cp        = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_SEGMENT_COUNT;
    cfg_data  = '0;
    rst_n     = 1'b0;
    items     = 0;
    settings  = 0;
    idling_on = 1'b1;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // zero length: arrays never fit
    write_reg(REG_SEGMENT_COUNT, 1);
    write_reg(REG_SUBTABLE_LENGTH, 0);
    look_up(0);

    // length past the store
    settle();
    write_reg(REG_SUBTABLE_LENGTH, 16383);
    look_up(65535);

    // zero segments scan nothing
    settle();
    write_reg(REG_SEGMENT_COUNT, 0);
    write_reg(REG_SUBTABLE_LENGTH, 16);
    look_up('h1234);

    // 1022 segments, the most that fit, arrays fill the store exactly; only segment 0
    // is ever read since its end code covers every code point
    settle();
    write_reg(REG_SEGMENT_COUNT, 1022);
    write_reg(REG_SUBTABLE_LENGTH, TABLE_BYTES_DEF);
    load_byte(14, 'hFF);            // end code 0xffff
    load_byte(15, 'hFF);
    load_byte(2060, 'h00);          // start code 0
    load_byte(2061, 'h00);
    load_byte(4104, 'h80);          // delta 0x8001
    load_byte(4105, 'h01);
    load_byte(6148, 'h07);          // range offset lands on the last store word
    load_byte(6149, 'hFA);
    load_byte(8190, 'hFF);
    load_byte(8191, 'hFF);
    look_up(0);                     // glyph word at the very end of the store
    look_up(1);                     // one word past the length
    look_up(65535);                 // far past the length
    load_byte(8190, 'h00);
    load_byte(8191, 'h00);
    look_up(0);                     // zero glyph word stays zero
    load_byte(6148, 'h00);
    load_byte(6149, 'h00);
    look_up(65535);                 // code point plus delta wraps
    look_up('h7FFF);

    // one byte short of the arrays
    settle();
    write_reg(REG_SUBTABLE_LENGTH, TABLE_BYTES_DEF - 1);
    look_up('h4000);

    // random subtables, each followed by a drain so registers change idle
    lookups_at_random = sb.lookups;
    while (items < ITEMS_TARGET || sb.lookups - lookups_at_random < 48) begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = $urandom_range(7, 12);
        default: n = $urandom_range(1, 6);
      endcase
      idling_on = (items < ITEMS_TARGET - CALM_ITEMS);
      build_table(n);
      repeat ($urandom_range(25, 45)) begin
        idling_on = (items < ITEMS_TARGET - CALM_ITEMS);
        // stray loads now and then, some landing inside the table
        if ($urandom_range(0, 9) == 0) begin
          load_byte($urandom_range(0, TABLE_BYTES_DEF - 1), $urandom_range(0, 255));
        end else begin
          random_lookup();
        end
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("run covered %0d byte loads and %0d lookups over %0d register writes",
             sb.loads, sb.lookups, settings);
    $display("lookup outcomes: %0d mapped, %0d glyph offset errors, %0d layout errors",
             sb.outcome_cnt[STATUS_OK], sb.outcome_cnt[STATUS_BAD_GLYPH],
             sb.outcome_cnt[STATUS_BAD_LAYOUT]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout with %0d lookups still unanswered", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
